@@ rtl/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, codes and constants of the timed segment sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

    // Table depth default
    localparam int DEFAULT_MAX_ENTRIES = 16;

    // Field widths
    localparam int OP_W       = 4;
    localparam int DT_W       = 16;
    localparam int DUR_W      = 24;
    localparam int SPEED_W    = 12;
    localparam int TIME_W     = 32;
    localparam int PROD_W     = DT_W + SPEED_W;
    localparam int SCALED_W   = PROD_W - 8;
    localparam int PROG_W     = 17;
    localparam int QUO_W      = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int ENTRY_W    = DUR_W + 3;

    // Arithmetic constants
    localparam logic [SPEED_W-1:0] SPEED_MIN    = 12'd26;
    localparam logic [SPEED_W-1:0] SPEED_RESET  = 12'd256;
    localparam logic [PROG_W-1:0]  PROGRESS_ONE = 17'h10000;
    localparam logic [TIME_W-1:0]  SAT32        = 32'hFFFF_FFFF;
    localparam int                 DIV_STEPS    = QUO_W;
    localparam int                 DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 2'd2;

    // Callback kinds
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FORWARD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BACKWARD = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 4'd0,
        OP_PLAY  = 4'd1,
        OP_PAUSE = 4'd2,
        OP_NEXT  = 4'd3,
        OP_PREV  = 4'd4,
        OP_FRONT = 4'd5,
        OP_BACK  = 4'd6,
        OP_PUSH  = 4'd7,
        OP_CLEAR = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ADD,
        ST_DLOAD,
        ST_DIV,
        ST_FIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_issue;
        logic add;
        logic div_load;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic tick_run;
        logic div_last;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/timed_segment_sequencer.sv @@
// ----------------------------------------------------------------------------
// timed_segment_sequencer
// Plays a table of timed segments with progress callbacks and cooldowns.
// ----------------------------------------------------------------------------
// Channel | Signals                                   | Transfer when
// --------+-------------------------------------------+--------------------------
// input   | i_in_valid/o_in_ready, operation fields    | i_in_valid & o_in_ready
// result  | o_out_valid/i_out_ready, result fields     | o_out_valid & i_out_ready
// config  | i_cfg_valid/o_cfg_ready, index, data       | i_cfg_valid & o_cfg_ready
//
// A tick that plays a segment goes from transfer to result through table
// read, speed multiply, elapsed add, then a 16-step restoring divider for the
// progress; other operations go straight to the commit. One item is in work
// at a time; the next item can transfer in the cycle the result appears.
// Reset is synchronous, active low; the table needs no clearing pass.
// A stalled result is held in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_segment_sequencer
    import tss_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [DT_W-1:0]       i_dt,
    input  wire logic [DUR_W-1:0]      i_duration,
    input  wire logic                  i_direction,
    input  wire logic                  i_has_forward,
    input  wire logic                  i_has_backward,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [IDX_W-1:0]      o_current_entry,
    output logic      [PROG_W-1:0]     o_progress,
    output logic      [KIND_W-1:0]     o_callback_kind,
    output logic                       o_is_playing,
    output logic                       o_is_waiting,
    output logic      [CNT_W-1:0]      o_entry_count,
    output logic                       o_rejected
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    tss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tss_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_write     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_dt            (i_dt),
        .i_duration      (i_duration),
        .i_direction     (i_direction),
        .i_has_forward   (i_has_forward),
        .i_has_backward  (i_has_backward),
        .o_current_entry (o_current_entry),
        .o_progress      (o_progress),
        .o_callback_kind (o_callback_kind),
        .o_is_playing    (o_is_playing),
        .o_is_waiting    (o_is_waiting),
        .o_entry_count   (o_entry_count),
        .o_rejected      (o_rejected)
    );

endmodule

`default_nettype wire

@@ rtl/tss_ram.sv @@
// ----------------------------------------------------------------------------
// tss_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tss_ctrl.sv @@
// ----------------------------------------------------------------------------
// tss_ctrl
// Controller: sequences one item through read, add, divide (ticks) and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_ctrl
    import tss_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_DECIDE;
            ST_DECIDE: n_state = i_status.tick_run ? ST_ADD : ST_FIN;
            ST_ADD:    n_state = ST_DLOAD;
            ST_DLOAD:  n_state = ST_DIV;
            ST_DIV:    if (i_status.div_last) n_state = ST_FIN;
            ST_FIN:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_DECIDE: o_cmd.rd_issue = 1'b1;
            ST_ADD:    o_cmd.add      = 1'b1;
            ST_DLOAD:  o_cmd.div_load = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_FIN:    o_cmd.commit   = out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Result register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tss_dp.sv @@
// ----------------------------------------------------------------------------
// tss_dp
// Datapath: sequencer state, segment table, speed multiply, progress divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_dp
    import tss_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic                  i_cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [DT_W-1:0]       i_dt,
    input  wire logic [DUR_W-1:0]      i_duration,
    input  wire logic                  i_direction,
    input  wire logic                  i_has_forward,
    input  wire logic                  i_has_backward,
    output logic      [IDX_W-1:0]      o_current_entry,
    output logic      [PROG_W-1:0]     o_progress,
    output logic      [KIND_W-1:0]     o_callback_kind,
    output logic                       o_is_playing,
    output logic                       o_is_waiting,
    output logic      [CNT_W-1:0]      o_entry_count,
    output logic                       o_rejected
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    // Captured item
    t_op               r_op;
    logic [DT_W-1:0]   r_dt;
    logic [DUR_W-1:0]  r_dur_in;
    logic              r_dir_in, r_hf_in, r_hb_in;

    // Configuration
    logic               r_loop;
    logic [SPEED_W-1:0] r_speed;
    logic [DUR_W-1:0]   r_cooldown;

    // Sequencer state
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic [TIME_W-1:0] r_ctimer, n_ctimer;
    logic              r_playing, n_playing;
    logic              r_waiting, n_waiting;

    // Tick work registers
    logic [PROD_W-1:0]    r_prod;
    logic [DUR_W-1:0]     r_ent_dur;
    logic                 r_ent_dir, r_ent_hf, r_ent_hb;
    logic [DUR_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [SPEED_W-1:0] eff_speed;
    logic [TIME_W:0]    elapsed_sum;
    logic [TIME_W-1:0]  elapsed_sat;
    logic [DUR_W:0]     rem_shift;
    logic               nonempty;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_wr;

    // Commit results
    logic [PROG_W-1:0]  n_progress;
    logic [KIND_W-1:0]  n_kind;
    logic               n_rejected;
    logic               do_adv, set_play;
    logic [CNT_W-1:0]   inc;
    logic               at_end;
    logic [TIME_W:0]    ctimer_sum;
    logic [TIME_W-1:0]  ctimer_sat;
    logic               finished;

    assign nonempty  = (r_count != '0) && (CNT_W'(r_cur) < r_count);
    assign eff_speed = (r_speed < SPEED_MIN) ? SPEED_MIN : r_speed;

    assign o_status.tick_run = (r_op == OP_TICK) && r_playing && nonempty && !r_waiting;
    assign o_status.div_last = (r_div_cnt == DIV_CNT_W'(1));

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_op'(i_operation);
            r_dt     <= i_dt;
            r_dur_in <= i_duration;
            r_dir_in <= i_direction;
            r_hf_in  <= i_has_forward;
            r_hb_in  <= i_has_backward;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop     <= 1'b0;
            r_speed    <= SPEED_RESET;
            r_cooldown <= '0;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                CFG_LOOP_ENABLE: r_loop     <= i_cfg_data[0];
                CFG_SPEED:       r_speed    <= i_cfg_data[SPEED_W-1:0];
                CFG_COOLDOWN:    r_cooldown <= i_cfg_data;
                default:         r_loop     <= r_loop;
            endcase
        end
    end

    // Segment table
    assign ram_wr = i_cmd.commit && (r_op == OP_PUSH) && (r_count < MAX_CNT);

    tss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (IDX_W'(r_count)),
        .i_wr_data ({r_dur_in, r_dir_in, r_hf_in, r_hb_in}),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_cur),
        .o_rd_data (ram_rdata)
    );

    // Speed scaling product
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_prod <= PROD_W'(r_dt) * PROD_W'(eff_speed);
        end
    end

    // Saturating elapsed update
    assign elapsed_sum = {1'b0, r_elapsed} + (TIME_W+1)'(r_prod[PROD_W-1:8]);
    assign elapsed_sat = elapsed_sum[TIME_W] ? SAT32 : elapsed_sum[TIME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_ent_dur <= ram_rdata[ENTRY_W-1:3];
            r_ent_dir <= ram_rdata[2];
            r_ent_hf  <= ram_rdata[1];
            r_ent_hb  <= ram_rdata[0];
        end
    end

    // Restoring divider: elapsed * 2^16 / duration, only used when elapsed < duration
    assign rem_shift = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= r_elapsed[DUR_W-1:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_shift >= {1'b0, r_ent_dur}) begin
                r_rem <= DUR_W'(rem_shift - {1'b0, r_ent_dur});
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_shift[DUR_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // Commit logic
    assign inc        = CNT_W'(r_cur) + CNT_W'(1);
    assign at_end     = (inc >= r_count);
    assign ctimer_sum = {1'b0, r_ctimer} + (TIME_W+1)'(r_dt);
    assign ctimer_sat = ctimer_sum[TIME_W] ? SAT32 : ctimer_sum[TIME_W-1:0];
    assign finished   = (r_elapsed >= TIME_W'(r_ent_dur));

    always_comb begin
        n_count    = r_count;
        n_cur      = r_cur;
        n_elapsed  = r_elapsed;
        n_ctimer   = r_ctimer;
        n_playing  = r_playing;
        n_waiting  = r_waiting;
        n_progress = '0;
        n_kind     = KIND_NONE;
        n_rejected = 1'b0;
        do_adv     = 1'b0;
        set_play   = 1'b0;

        case (r_op)
            OP_TICK: begin
                if (r_playing && nonempty) begin
                    if (!r_waiting) begin
                        if (!r_ent_dir) begin
                            if (r_ent_hf) n_kind = KIND_FORWARD;
                        end else if (r_ent_hb) begin
                            n_kind = KIND_BACKWARD;
                        end
                        if (n_kind != KIND_NONE) begin
                            n_progress = finished ? PROGRESS_ONE : {1'b0, r_quo};
                        end
                        if (finished) begin
                            if (r_cooldown != '0) begin
                                n_waiting = 1'b1;
                                n_ctimer  = '0;
                            end else begin
                                do_adv = 1'b1;
                            end
                        end
                    end else begin
                        n_ctimer = ctimer_sat;
                        if (ctimer_sat >= TIME_W'(r_cooldown)) begin
                            n_waiting = 1'b0;
                            do_adv    = 1'b1;
                        end
                    end
                end
            end
            OP_PLAY: begin
                if (r_count != '0) n_playing = 1'b1;
            end
            OP_PAUSE: n_playing = 1'b0;
            OP_NEXT: begin
                if (r_count != '0) begin
                    do_adv   = 1'b1;
                    set_play = 1'b1;
                end
            end
            OP_PREV: begin
                if (r_count != '0) begin
                    if (r_loop) begin
                        n_cur = (r_cur == '0) ? IDX_W'(r_count - CNT_W'(1))
                                              : r_cur - IDX_W'(1);
                    end else if (r_cur != '0) begin
                        n_cur = r_cur - IDX_W'(1);
                    end
                    n_elapsed = '0;
                    n_playing = 1'b1;
                end
            end
            OP_FRONT: begin
                if (r_count != '0) begin
                    n_cur     = '0;
                    n_elapsed = '0;
                end
            end
            OP_BACK: begin
                if (r_count != '0) begin
                    n_cur     = IDX_W'(r_count - CNT_W'(1));
                    n_elapsed = '0;
                end
            end
            OP_PUSH: begin
                if (r_count >= MAX_CNT) begin
                    n_rejected = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                n_count   = '0;
                n_cur     = '0;
                n_elapsed = '0;
                n_playing = 1'b0;
            end
            default: n_rejected = 1'b0;
        endcase

        // Move to the following segment, wrap or stop at the end
        if (do_adv && (r_count != '0)) begin
            if (r_loop) begin
                n_cur     = at_end ? '0 : IDX_W'(inc);
                n_elapsed = '0;
            end else if (!at_end) begin
                n_cur     = IDX_W'(inc);
                n_elapsed = '0;
            end else begin
                n_playing = 1'b0;
            end
        end
        if (set_play) n_playing = 1'b1;
    end

    // Sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cur     <= '0;
            r_elapsed <= '0;
            r_ctimer  <= '0;
            r_playing <= 1'b0;
            r_waiting <= 1'b0;
        end else if (i_cmd.add) begin
            r_elapsed <= elapsed_sat;
        end else if (i_cmd.commit) begin
            r_count   <= n_count;
            r_cur     <= n_cur;
            r_elapsed <= n_elapsed;
            r_ctimer  <= n_ctimer;
            r_playing <= n_playing;
            r_waiting <= n_waiting;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_current_entry <= n_cur;
            o_progress      <= n_progress;
            o_callback_kind <= n_kind;
            o_is_playing    <= n_playing;
            o_is_waiting    <= n_waiting;
            o_entry_count   <= n_count;
            o_rejected      <= n_rejected;
        end
    end

endmodule

`default_nettype wire
